// ===== hdl/wdp_pkg.sv =====
// shared types and constants of the wav duration parser
package wdp_pkg;

   localparam logic [31:0] TAG_RIFF    = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE    = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT     = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA    = 32'h6461_7461;
   localparam logic [31:0] FMT_MIN_LEN = 32'd16;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_BAD_HEADER = 2'd1;
   localparam logic [1:0] ST_EARLY_END  = 2'd2;
   localparam logic [1:0] ST_ZERO_FIELD = 2'd3;

   localparam int DIV_STEPS = 32;

   typedef enum logic [3:0] {
      PH_HEADER,
      PH_HEADER_BAD,
      PH_CHUNK_HDR,
      PH_FMT,
      PH_SKIP,
      PH_DONE,
      PH_MUL_A,
      PH_MUL_B,
      PH_CHECK,
      PH_DIV,
      PH_FINISH
   } phase_type;

   typedef struct packed {
      logic       shift_tag;
      logic       clear_len;
      logic       len_byte_en;
      logic [1:0] byte_sel;
      logic       chan_en;
      logic       rate_en;
      logic       bits_en;
      logic       skip_load;
      logic       skip_fmt;
      logic       skip_dec;
      logic       clear_all;
      logic       mul_a;
      logic       mul_b;
      logic       div_start;
      logic       div_step;
      logic       out_load;
      logic [1:0] out_status;
      logic       out_quot;
   } dp_cmd_type;

   typedef struct packed {
      logic tag_riff;
      logic tag_wave;
      logic tag_fmt;
      logic tag_data;
      logic len_ge_min;
      logic skip_next_zero;
      logic skip_one;
      logic zero_field;
      logic div_last;
   } dp_status_type;

endpackage

// ===== hdl/wdp_datapath.sv =====
// datapath: header fields, skip counter, byte-rate multiply, shift-subtract divider, result register
module wdp_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            req_data_byte,
   input  wdp_pkg::dp_cmd_type   cmd,
   output wdp_pkg::dp_status_type status,
   output logic [31:0]           rsp_duration_seconds,
   output logic [1:0]            rsp_status
);
   import wdp_pkg::*;

   localparam int CNT_W = $clog2(DIV_STEPS);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

   logic [31:0] tag_ff, tag_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] skip_ff, skip_in;
   logic [15:0] chan_ff, chan_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] bits_ff, bits_in;
   logic [31:0] prod_ff;
   logic [31:0] bps_ff;
   logic [31:0] rem_ff;
   logic [31:0] quot_ff;
   logic [CNT_W-1:0] div_cnt_ff;
   logic [31:0] dur_ff;
   logic [1:0]  stat_ff;

   logic [31:0] tag_nx, len_nx, skip_nx;
   logic [32:0] rem_sh;
   logic        rem_ge;
   logic [47:0] prod_full;
   logic [44:0] bps_full;

   always_comb begin
      tag_nx = cmd.shift_tag ? {tag_ff[23:0], req_data_byte} : tag_ff;
      len_nx = len_ff;
      if (cmd.clear_len) begin
         len_nx = '0;
      end else if (cmd.len_byte_en) begin
         len_nx[8*cmd.byte_sel +: 8] = req_data_byte;
      end
      // odd chunk sizes carry one pad byte, wrapping at 32 bits
      if (cmd.skip_fmt) begin
         skip_nx = len_nx - FMT_MIN_LEN + {31'd0, len_nx[0]};
      end else begin
         skip_nx = len_nx + {31'd0, len_nx[0]};
      end
   end

   always_comb begin
      tag_in  = tag_nx;
      len_in  = len_nx;
      skip_in = skip_ff;
      chan_in = chan_ff;
      rate_in = rate_ff;
      bits_in = bits_ff;
      if (cmd.skip_load) begin
         skip_in = skip_nx;
      end else if (cmd.skip_dec) begin
         skip_in = skip_ff - 32'd1;
      end
      if (cmd.chan_en) begin
         chan_in = cmd.byte_sel[0] ? {req_data_byte, chan_ff[7:0]} : {8'd0, req_data_byte};
      end
      if (cmd.bits_en) begin
         bits_in = cmd.byte_sel[0] ? {req_data_byte, bits_ff[7:0]} : {8'd0, req_data_byte};
      end
      if (cmd.rate_en) begin
         if (cmd.byte_sel == 2'd0) begin
            rate_in = {24'd0, req_data_byte};
         end else begin
            rate_in[8*cmd.byte_sel +: 8] = req_data_byte;
         end
      end
      if (cmd.clear_all) begin
         tag_in  = '0;
         len_in  = '0;
         skip_in = '0;
         chan_in = '0;
         rate_in = '0;
         bits_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff  <= '0;
         len_ff  <= '0;
         skip_ff <= '0;
         chan_ff <= '0;
         rate_ff <= '0;
         bits_ff <= '0;
      end else begin
         tag_ff  <= tag_in;
         len_ff  <= len_in;
         skip_ff <= skip_in;
         chan_ff <= chan_in;
         rate_ff <= rate_in;
         bits_ff <= bits_in;
      end
   end

   // byte rate in two registered multiplies, kept modulo 2^32
   assign prod_full = rate_ff * chan_ff;
   assign bps_full  = prod_ff * bits_ff[15:3];

   always_ff @(posedge clock) begin
      if (cmd.mul_a) begin
         prod_ff <= prod_full[31:0];
      end
      if (cmd.mul_b) begin
         bps_ff <= bps_full[31:0];
      end
   end

   // restoring divider, one quotient bit per cycle
   assign rem_sh = {rem_ff, quot_ff[31]};
   assign rem_ge = rem_sh >= {1'b0, bps_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff     <= '0;
         quot_ff    <= len_ff;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff     <= rem_ge ? 32'(rem_sh - {1'b0, bps_ff}) : rem_sh[31:0];
         quot_ff    <= {quot_ff[30:0], rem_ge};
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         dur_ff  <= cmd.out_quot ? quot_ff : 32'd0;
         stat_ff <= cmd.out_status;
      end
   end

   assign rsp_duration_seconds = dur_ff;
   assign rsp_status           = stat_ff;

   assign status.tag_riff       = tag_nx == TAG_RIFF;
   assign status.tag_wave       = tag_nx == TAG_WAVE;
   assign status.tag_fmt        = tag_nx == TAG_FMT;
   assign status.tag_data       = tag_nx == TAG_DATA;
   assign status.len_ge_min     = len_nx >= FMT_MIN_LEN;
   assign status.skip_next_zero = skip_nx == 32'd0;
   assign status.skip_one       = skip_ff == 32'd1;
   assign status.zero_field     = (rate_ff == 32'd0) || (chan_ff == 16'd0) ||
                                  (bits_ff == 16'd0) || (len_ff == 32'd0) ||
                                  (bps_ff == 32'd0);
   assign status.div_last       = div_cnt_ff == DIV_LAST;

endmodule

// ===== hdl/wdp_ctrl.sv =====
// controller: parse phase state machine, byte position counter and result handshake
module wdp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_last_byte,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  wdp_pkg::dp_status_type status,
   output wdp_pkg::dp_cmd_type    cmd
);
   import wdp_pkg::*;

   localparam logic [3:0] HDR_RIFF_END  = 4'd3;
   localparam logic [3:0] HDR_END       = 4'd11;
   localparam logic [3:0] CHDR_LEN_LO   = 4'd4;
   localparam logic [3:0] CHDR_END      = 4'd7;
   localparam logic [3:0] FMT_CHAN_LO   = 4'd2;
   localparam logic [3:0] FMT_CHAN_HI   = 4'd3;
   localparam logic [3:0] FMT_RATE_LO   = 4'd4;
   localparam logic [3:0] FMT_RATE_HI   = 4'd7;
   localparam logic [3:0] FMT_BITS_LO   = 4'd14;
   localparam logic [3:0] FMT_END       = 4'd15;

   phase_type   phase_ff, phase_in;
   logic [3:0]  count_ff, count_in;
   logic        last_pend_ff, last_pend_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic        out_free;
   logic        busy;
   logic        need_out;
   logic        acc;
   logic        bad_hdr;
   logic        to_compute;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign busy      = phase_ff inside {PH_MUL_A, PH_MUL_B, PH_CHECK, PH_DIV, PH_FINISH};
   // only an item that may write a result at once waits for the result register
   assign need_out  = req_last_byte ||
                      (count_ff == HDR_END && phase_ff inside {PH_HEADER, PH_HEADER_BAD});
   assign req_stall = busy || (!out_free && need_out);
   assign acc       = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         count_ff     <= '0;
         last_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         last_pend_ff <= last_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      cmd          = '0;
      phase_in     = phase_ff;
      count_in     = count_ff;
      last_pend_in = last_pend_ff;
      bad_hdr      = 1'b0;
      to_compute   = 1'b0;

      case (phase_ff)
         PH_HEADER, PH_HEADER_BAD: begin
            if (acc) begin
               cmd.shift_tag = 1'b1;
               bad_hdr = (phase_ff == PH_HEADER_BAD) ||
                         (count_ff == HDR_RIFF_END && !status.tag_riff);
               if (count_ff == HDR_END) begin
                  if (bad_hdr || !status.tag_wave) begin
                     cmd.out_load   = 1'b1;
                     cmd.out_status = ST_BAD_HEADER;
                     phase_in       = PH_DONE;
                  end else begin
                     phase_in = PH_CHUNK_HDR;
                     count_in = '0;
                  end
               end else begin
                  count_in = count_ff + 1'b1;
                  if (bad_hdr) begin
                     phase_in = PH_HEADER_BAD;
                  end
               end
            end
         end
         PH_CHUNK_HDR: begin
            if (acc) begin
               cmd.byte_sel = count_ff[1:0];
               if (count_ff < CHDR_LEN_LO) begin
                  cmd.shift_tag = 1'b1;
                  cmd.clear_len = (count_ff == 4'd0);
               end else begin
                  cmd.len_byte_en = 1'b1;
               end
               if (count_ff == CHDR_END) begin
                  count_in = '0;
                  if (status.tag_fmt && status.len_ge_min) begin
                     phase_in = PH_FMT;
                  end else if (status.tag_data) begin
                     // end of stream is handled once the result is out
                     phase_in     = PH_MUL_A;
                     to_compute   = 1'b1;
                     last_pend_in = req_last_byte;
                  end else begin
                     cmd.skip_load = 1'b1;
                     phase_in = status.skip_next_zero ? PH_CHUNK_HDR : PH_SKIP;
                  end
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         PH_FMT: begin
            if (acc) begin
               cmd.byte_sel = count_ff[1:0];
               cmd.chan_en  = (count_ff == FMT_CHAN_LO) || (count_ff == FMT_CHAN_HI);
               cmd.rate_en  = count_ff inside {[FMT_RATE_LO:FMT_RATE_HI]};
               cmd.bits_en  = (count_ff == FMT_BITS_LO) || (count_ff == FMT_END);
               if (count_ff == FMT_END) begin
                  cmd.skip_load = 1'b1;
                  cmd.skip_fmt  = 1'b1;
                  count_in      = '0;
                  phase_in      = status.skip_next_zero ? PH_CHUNK_HDR : PH_SKIP;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         PH_SKIP: begin
            if (acc) begin
               cmd.skip_dec = 1'b1;
               if (status.skip_one) begin
                  phase_in = PH_CHUNK_HDR;
                  count_in = '0;
               end
            end
         end
         PH_DONE: begin
         end
         PH_MUL_A: begin
            cmd.mul_a = 1'b1;
            phase_in  = PH_MUL_B;
         end
         PH_MUL_B: begin
            cmd.mul_b = 1'b1;
            phase_in  = PH_CHECK;
         end
         PH_CHECK: begin
            if (status.zero_field) begin
               if (out_free) begin
                  cmd.out_load   = 1'b1;
                  cmd.out_status = ST_ZERO_FIELD;
               end
            end else begin
               cmd.div_start = 1'b1;
               phase_in      = PH_DIV;
            end
         end
         PH_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               phase_in = PH_FINISH;
            end
         end
         PH_FINISH: begin
            if (out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = ST_OK;
               cmd.out_quot   = 1'b1;
            end
         end
         default: begin
            phase_in = PH_HEADER;
            count_in = '0;
         end
      endcase

      // result of a data chunk is out: either wait for the end or start over
      if (busy && cmd.out_load) begin
         if (last_pend_ff) begin
            phase_in      = PH_HEADER;
            count_in      = '0;
            last_pend_in  = 1'b0;
            cmd.clear_all = 1'b1;
         end else begin
            phase_in = PH_DONE;
         end
      end

      if (acc && req_last_byte && !to_compute) begin
         if (!cmd.out_load && phase_ff != PH_DONE) begin
            cmd.out_load   = 1'b1;
            cmd.out_status = ST_EARLY_END;
            cmd.out_quot   = 1'b0;
         end
         phase_in      = PH_HEADER;
         count_in      = '0;
         cmd.clear_all = 1'b1;
      end

      rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);
   end

endmodule

// ===== hdl/wav_duration_parser.sv =====
// top level of the wav duration parser
// Takes one file byte per cycle while walking the RIFF header and chunks, unless held by a
// stall. When the header of the data chunk completes, the block stops taking bytes while it
// runs the two byte-rate multiplies, the zero check, the one-bit-per-cycle shift-subtract
// divider and the load of the result (a zero field skips the divide). Other results (bad
// header, early end) come with the byte that causes them. The single result register lets
// parsing continue while a result waits; only the twelfth header byte and the last byte of
// a file, which may write a new result at once, are held until the register is free.
module wav_duration_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_duration_seconds,
   output logic [1:0]  rsp_status
);
   import wdp_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   wdp_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_byte (req_last_byte),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .status        (status),
      .cmd           (cmd)
   );

   wdp_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .req_data_byte        (req_data_byte),
      .cmd                  (cmd),
      .status               (status),
      .rsp_duration_seconds (rsp_duration_seconds),
      .rsp_status           (rsp_status)
   );

endmodule

// ===== test/wav_duration_parser_tb.sv =====
// testbench of the wav duration parser: directed and random wav files checked against a predictor
module wav_duration_parser_tb;
   import wdp_pkg::*;

   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 64;
   localparam int DIRECTED_ROWS   = 23;

   localparam logic [1:0] HDR_GOOD     = 2'd0;
   localparam logic [1:0] HDR_BAD_RIFF = 2'd1;
   localparam logic [1:0] HDR_BAD_WAVE = 2'd2;
   localparam logic [1:0] HDR_NOISE    = 2'd3;

   // one file to stream; cut keeps only the first bytes (for noise, the length)
   typedef struct packed {
      logic [1:0]  hdr;
      bit          junk;
      logic [31:0] junk_len;
      logic [31:0] fmts;
      logic [31:0] fmt_len;
      logic [31:0] chans;
      logic [31:0] rate;
      logic [31:0] bits;
      logic [31:0] data_len;
      logic [31:0] tail;
      logic [31:0] cut;
      bit          typed;
      logic [31:0] want_dur;
      logic [1:0]  want_st;
   } wav_file_type;

   typedef struct packed {
      logic [31:0] dur;
      logic [1:0]  st;
   } duration_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_duration_seconds;
   logic [1:0]  rsp_status;

   wav_duration_parser dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_data_byte        (req_data_byte),
      .req_last_byte        (req_last_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_duration_seconds (rsp_duration_seconds),
      .rsp_status           (rsp_status)
   );

   always #5 clock = ~clock;

   // predictor state
   phase_type   ph;
   logic [4:0]  fld_cnt;
   logic [31:0] tag_sr;
   logic [31:0] chunk_len;
   logic [31:0] skip_cnt;
   logic [15:0] chan_r;
   logic [31:0] rate_r;
   logic [15:0] bits_r;
   logic        answered;

   duration_type pending_durations[$];
   logic [7:0]   file_bytes[$];
   wav_file_type directed_files [DIRECTED_ROWS];

   logic        typed_on = 1'b0;
   logic [31:0] typed_dur = '0;
   logic [1:0]  typed_st = ST_OK;
   logic        hold_off_req = 1'b0;
   int          req_gap_pct = 20;
   int          rsp_stall_pct = 20;
   int          parsed_count = 0;
   int          fail_count = 0;
   int          cycle_count = 0;

   function automatic void clear_parser_state();
      ph = PH_HEADER;
      fld_cnt = '0;
      tag_sr = '0;
      chunk_len = '0;
      skip_cnt = '0;
      chan_r = '0;
      rate_r = '0;
      bits_r = '0;
      answered = 1'b0;
   endfunction

   function automatic void start_skip(input logic [31:0] n);
      skip_cnt = n;
      fld_cnt = '0;
      ph = (n == 32'd0) ? PH_CHUNK_HDR : PH_SKIP;
   endfunction

   // advances the parser by one byte; returns 1 when the byte yields a duration
   function automatic bit predict_duration(input logic [7:0] b, input logic lst,
                                           output logic [31:0] dur, output logic [1:0] st);
      logic [4:0]  c;
      logic [31:0] bps;
      bit          got;
      c = fld_cnt;
      got = 1'b0;
      dur = '0;
      st = ST_OK;
      case (ph)
         PH_HEADER, PH_HEADER_BAD: begin
            tag_sr = {tag_sr[23:0], b};
            if (c == 5'd3 && tag_sr != TAG_RIFF) ph = PH_HEADER_BAD;
            if (c == 5'd11) begin
               if (ph == PH_HEADER_BAD || tag_sr != TAG_WAVE) begin
                  got = 1'b1;
                  st = ST_BAD_HEADER;
                  answered = 1'b1;
                  ph = PH_DONE;
               end else begin
                  ph = PH_CHUNK_HDR;
                  fld_cnt = '0;
               end
            end else begin
               fld_cnt = c + 5'd1;
            end
         end
         PH_CHUNK_HDR: begin
            if (c < 5'd4) begin
               tag_sr = {tag_sr[23:0], b};
               if (c == 5'd0) chunk_len = '0;
            end else begin
               chunk_len[8 * (c - 5'd4) +: 8] = b;
            end
            if (c >= 5'd7) begin
               fld_cnt = '0;
               if (tag_sr == TAG_FMT && chunk_len >= FMT_MIN_LEN) begin
                  ph = PH_FMT;
               end else if (tag_sr == TAG_DATA) begin
                  // byte rate wraps at 32 bits
                  bps = rate_r * 32'(chan_r) * 32'(bits_r / 16'd8);
                  got = 1'b1;
                  answered = 1'b1;
                  ph = PH_DONE;
                  if (rate_r == 32'd0 || chan_r == 16'd0 || bits_r == 16'd0 ||
                      chunk_len == 32'd0 || bps == 32'd0) begin
                     st = ST_ZERO_FIELD;
                  end else begin
                     dur = chunk_len / bps;
                  end
               end else begin
                  start_skip(chunk_len + 32'(chunk_len[0]));
               end
            end else begin
               fld_cnt = c + 5'd1;
            end
         end
         PH_FMT: begin
            if (c == 5'd2) chan_r = {8'd0, b};
            else if (c == 5'd3) chan_r[15:8] = b;
            else if (c == 5'd4) rate_r = {24'd0, b};
            else if (c >= 5'd5 && c <= 5'd7) rate_r[8 * (c - 5'd4) +: 8] = b;
            else if (c == 5'd14) bits_r = {8'd0, b};
            else if (c == 5'd15) bits_r[15:8] = b;
            if (c >= 5'd15) start_skip(chunk_len - FMT_MIN_LEN + 32'(chunk_len[0]));
            else fld_cnt = c + 5'd1;
         end
         PH_SKIP: begin
            skip_cnt = skip_cnt - 32'd1;
            if (skip_cnt == 32'd0) begin
               ph = PH_CHUNK_HDR;
               fld_cnt = '0;
            end
         end
         default: ;
      endcase
      if (lst) begin
         if (!got && !answered) begin
            got = 1'b1;
            st = ST_EARLY_END;
            dur = '0;
         end
         clear_parser_state();
      end
      return got;
   endfunction

   function automatic int idle_len(input int pct);
      if ($urandom_range(0, 99) >= pct) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(12, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic void put_bytes(input logic [31:0] v, input int n, input bit big);
      logic [7:0] b;
      for (int i = 0; i < n; i++) begin
         b = big ? v[8 * (n - 1 - i) +: 8] : v[8 * i +: 8];
         file_bytes = {file_bytes, b};
      end
   endfunction

   function automatic void put_noise(input logic [31:0] n);
      logic [7:0] b;
      repeat (n) begin
         b = 8'($urandom());
         file_bytes = {file_bytes, b};
      end
   endfunction

   function automatic void build_file(input wav_file_type f);
      logic [31:0] riff_tag;
      logic [31:0] wave_tag;
      bit          fmt_final;
      file_bytes.delete();
      if (f.hdr == HDR_NOISE) begin
         put_noise(f.cut);
         return;
      end
      riff_tag = TAG_RIFF;
      wave_tag = TAG_WAVE;
      if (f.hdr == HDR_BAD_RIFF)
         riff_tag ^= 32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3));
      if (f.hdr == HDR_BAD_WAVE)
         wave_tag ^= 32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3));
      put_bytes(riff_tag, 4, 1'b1);
      put_bytes($urandom(), 4, 1'b0);
      put_bytes(wave_tag, 4, 1'b1);
      if (f.junk) begin
         put_bytes($urandom(), 4, 1'b1);
         put_bytes(f.junk_len, 4, 1'b0);
         put_noise(f.junk_len + 32'(f.junk_len[0]));
      end
      for (int i = 0; i < f.fmts; i++) begin
         // only the final fmt chunk carries the row's values
         fmt_final = (i == f.fmts - 1);
         put_bytes(TAG_FMT, 4, 1'b1);
         put_bytes(f.fmt_len, 4, 1'b0);
         if (f.fmt_len >= FMT_MIN_LEN) begin
            put_noise(2);
            put_bytes(fmt_final ? f.chans : $urandom(), 2, 1'b0);
            put_bytes(fmt_final ? f.rate : $urandom(), 4, 1'b0);
            put_noise(6);
            put_bytes(fmt_final ? f.bits : $urandom(), 2, 1'b0);
            put_noise(f.fmt_len - FMT_MIN_LEN + 32'(f.fmt_len[0]));
         end else begin
            put_noise(f.fmt_len + 32'(f.fmt_len[0]));
         end
      end
      put_bytes(TAG_DATA, 4, 1'b1);
      put_bytes(f.data_len, 4, 1'b0);
      put_noise(f.tail);
      while (f.cut != 0 && file_bytes.size() > f.cut) void'(file_bytes.pop_back());
   endfunction

   function automatic wav_file_type random_file();
      wav_file_type f;
      int unsigned  kind;
      kind = $urandom_range(0, 99);
      f.hdr = HDR_GOOD;
      f.junk = ($urandom_range(0, 2) == 0);
      f.junk_len = $urandom_range(0, 9);
      f.fmts = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : 1;
      f.fmt_len = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 22) : 16;
      f.chans = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 'hFFFF) : $urandom_range(1, 8);
      case ($urandom_range(0, 5))
         0: f.rate = $urandom();
         1: f.rate = $urandom_range(0, 3);
         2: f.rate = 8000;
         3: f.rate = 22050;
         4: f.rate = 44100;
         default: f.rate = 48000;
      endcase
      if ($urandom_range(0, 7) == 0) f.bits = $urandom_range(0, 'hFFFF);
      else if ($urandom_range(0, 7) == 0) f.bits = $urandom_range(0, 40);
      else f.bits = 8 * $urandom_range(1, 4);
      f.data_len = ($urandom_range(0, 15) == 0) ? 0 : $urandom();
      f.tail = $urandom_range(0, 4);
      f.cut = 0;
      f.typed = 1'b0;
      f.want_dur = '0;
      f.want_st = ST_OK;
      // mostly complete files, then truncated ones, then headers gone wrong and plain noise
      if (kind >= 75 && kind < 88) begin
         f.cut = $urandom_range(1, 60);
      end else if (kind >= 88 && kind < 94) begin
         f.hdr = ($urandom_range(0, 1) == 0) ? HDR_BAD_RIFF : HDR_BAD_WAVE;
      end else if (kind >= 94) begin
         f.hdr = HDR_NOISE;
         f.cut = $urandom_range(1, 40);
      end
      return f;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic lst);
      int gap;
      gap = idle_len(req_gap_pct);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= lst;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_file(input wav_file_type f);
      build_file(f);
      typed_on = f.typed;
      typed_dur = f.want_dur;
      typed_st = f.want_st;
      foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
      typed_on = 1'b0;
   endtask

   // input acceptance is handled before the result so expectations are in place first
   always @(posedge clock) begin : watch
      logic [31:0]  d;
      logic [1:0]   s;
      duration_type want;
      duration_type fresh;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            if (ph != PH_DONE) parsed_count++;
            if (predict_duration(req_data_byte, req_last_byte, d, s)) begin
               if (typed_on) begin
                  d = typed_dur;
                  s = typed_st;
               end
               fresh.dur = d;
               fresh.st = s;
               pending_durations = {pending_durations, fresh};
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_durations.size() == 0) begin
               $error("result with nothing expected: duration_seconds %0d status %0d",
                      rsp_duration_seconds, rsp_status);
               fail_count++;
            end else begin
               want = pending_durations.pop_front();
               if (rsp_duration_seconds !== want.dur) begin
                  $error("duration_seconds expected %0d, got %0d", want.dur,
                         rsp_duration_seconds);
                  fail_count++;
               end
               if (rsp_status !== want.st) begin
                  $error("status expected %0d, got %0d", want.st, rsp_status);
                  fail_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[wav_duration_parser] ERROR");
         $finish;
      end
   end

   // receiver: random stall bursts, or one long hold-off when asked
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            n = idle_len(rsp_stall_pct);
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(negedge clock);
            end
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int file_num;
      clear_parser_state();
      // hdr, junk, junk_len, fmts, fmt_len, chans, rate, bits, data_len, tail, cut,
      // typed, duration, status
      directed_files = '{
         // stream ends on its first byte
         '{HDR_GOOD, 1'b0, 0, 1, 16, 2, 44100, 16, 1000, 0, 1, 1'b1, 0, ST_EARLY_END},
         '{HDR_BAD_RIFF, 1'b0, 0, 1, 16, 2, 44100, 16, 1000, 4, 0, 1'b1, 0, ST_BAD_HEADER},
         '{HDR_BAD_WAVE, 1'b0, 0, 1, 16, 2, 44100, 16, 1000, 4, 0, 1'b1, 0, ST_BAD_HEADER},
         // bad header and last byte together: header error wins
         '{HDR_BAD_RIFF, 1'b0, 0, 1, 16, 2, 44100, 16, 1000, 0, 12, 1'b1, 0, ST_BAD_HEADER},
         '{HDR_GOOD, 1'b0, 0, 1, 16, 2, 44100, 16, 1000, 0, 12, 1'b1, 0, ST_EARLY_END},
         '{HDR_GOOD, 1'b0, 0, 1, 16, 2, 44100, 16, 1764000, 2, 0, 1'b0, 0, ST_OK},
         '{HDR_GOOD, 1'b0, 0, 1, 16, 1, 1, 8, 'hFFFFFFFF, 0, 0, 1'b1, 'hFFFFFFFF, ST_OK},
         '{HDR_GOOD, 1'b0, 0, 1, 16, 'hFFFF, 'hFFFFFFFF, 'hFFFF, 'hFFFFFFFF, 0, 0,
           1'b0, 0, ST_OK},
         // data before any fmt chunk
         '{HDR_GOOD, 1'b0, 0, 0, 16, 2, 44100, 16, 100, 0, 0, 1'b1, 0, ST_ZERO_FIELD},
         '{HDR_GOOD, 1'b0, 0, 1, 16, 0, 44100, 16, 1000, 0, 0, 1'b1, 0, ST_ZERO_FIELD},
         '{HDR_GOOD, 1'b0, 0, 1, 16, 2, 0, 16, 1000, 0, 0, 1'b1, 0, ST_ZERO_FIELD},
         '{HDR_GOOD, 1'b0, 0, 1, 16, 2, 44100, 0, 1000, 0, 0, 1'b1, 0, ST_ZERO_FIELD},
         // fewer than 8 bits per sample gives zero bytes per sample
         '{HDR_GOOD, 1'b0, 0, 1, 16, 2, 44100, 7, 1000, 0, 0, 1'b1, 0, ST_ZERO_FIELD},
         '{HDR_GOOD, 1'b0, 0, 1, 16, 2, 44100, 16, 0, 0, 0, 1'b1, 0, ST_ZERO_FIELD},
         // byte rate wraps to zero
         '{HDR_GOOD, 1'b0, 0, 1, 16, 2, 'h80000000, 8, 1000, 0, 0, 1'b1, 0, ST_ZERO_FIELD},
         // fmt chunk too short is skipped, so channels stay zero
         '{HDR_GOOD, 1'b0, 0, 1, 15, 2, 44100, 16, 1000, 0, 0, 1'b1, 0, ST_ZERO_FIELD},
         '{HDR_GOOD, 1'b0, 0, 1, 19, 6, 48000, 24, 'h12345678, 0, 0, 1'b0, 0, ST_OK},
         '{HDR_GOOD, 1'b0, 0, 2, 16, 1, 8000, 8, 80000, 0, 0, 1'b0, 0, ST_OK},
         '{HDR_GOOD, 1'b1, 3, 1, 16, 1, 22050, 16, 441000, 0, 0, 1'b0, 0, ST_OK},
         '{HDR_GOOD, 1'b1, 0, 1, 16, 2, 22050, 8, 441000, 0, 0, 1'b0, 0, ST_OK},
         // odd all-ones size pads to a zero skip
         '{HDR_GOOD, 1'b1, 'hFFFFFFFF, 1, 16, 2, 44100, 32, 'hFFFFFFFF, 0, 0,
           1'b0, 0, ST_OK},
         '{HDR_GOOD, 1'b0, 0, 1, 16, 2, 44100, 16, 1000, 0, 30, 1'b1, 0, ST_EARLY_END},
         '{HDR_GOOD, 1'b1, 20, 1, 16, 2, 44100, 16, 1000, 0, 25, 1'b1, 0, ST_EARLY_END}
      };
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed_files[i]) send_file(directed_files[i]);
      file_num = 0;
      while (parsed_count < 2000 || file_num < 40) begin
         if (file_num == 2 || file_num == 25) hold_off_req = 1'b1;
         req_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
         rsp_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
         send_file(random_file());
         file_num++;
      end
      req_valid <= 1'b0;
      while (pending_durations.size() != 0) @(posedge clock);
      // long enough for the multiply and divide of a late data chunk
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("[wav_duration_parser] OK");
      else
         $display("[wav_duration_parser] ERROR");
      $finish;
   end

endmodule
